// File: design/svpt_pkg.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother package
// Shared constants, payload types and control structs for the smoother.
// ----------------------------------------------------------------------------
package svpt_pkg;

   localparam int DUTY_BITS = 14;
   localparam int DIGIT_W = 2;
   localparam int DIGIT_MAX = (1 << DIGIT_W) - 1;

   localparam int PAN_LIMIT = 11520;
   localparam int TILT_LIMIT = 7680;
   localparam int PERIOD_US = 20000;
   localparam int GAIN_FRAC = 8;

   localparam int TARGET_W = 16;
   localparam int ANGLE_W = 15;
   localparam int ANGLE_TILT_W = 14;
   localparam int DUTY_W = 14;
   localparam int GAIN_W = 9;
   localparam int DEADBAND_W = 12;
   localparam int PULSE_W = 15;
   localparam int PLS_W = PULSE_W + 1;
   localparam int SUM_W = 18;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 15;

   localparam int GAIN_RESET = 38;
   localparam int DEADBAND_RESET = 128;
   localparam int PULSE_MIN_RESET = 1000;
   localparam int PULSE_MAX_RESET = 2000;

   localparam int MC_W = 16;
   localparam int MR_W = ((PULSE_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
   localparam int PROD_W = MC_W + MR_W;
   localparam int MUL_STEPS = MR_W / DIGIT_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);

   localparam int REM_W = 15;
   localparam int QUOT_MIN_W = (DUTY_BITS + 2 > 16) ? DUTY_BITS + 2 : 16;
   localparam int QUOT_W = ((QUOT_MIN_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
   localparam int DVD_W = QUOT_W + REM_W;
   localparam int DIV_STEPS = QUOT_W / DIGIT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;
   localparam int DUTY_EXT_W = (DUTY_BITS > DUTY_W) ? DUTY_BITS : DUTY_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN,
      CSR_DEADBAND,
      CSR_PULSE_MIN,
      CSR_PULSE_MAX
   } csr_index_type;

   typedef logic signed [TARGET_W-1:0] target_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [MC_W-1:0] mc_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic [GAIN_W-1:0]     gain;
      logic [DEADBAND_W-1:0] deadband;
      logic [PULSE_W-1:0]    pulse_min_us;
      logic [PULSE_W-1:0]    pulse_max_us;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } axis_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } axis_status_type;

endpackage

// File: design/svpt_if.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface svpt_req_if;
   logic                  valid;
   logic                  ready;
   svpt_pkg::target_type  target_pan;
   svpt_pkg::target_type  target_tilt;

   modport source (output valid, output target_pan, output target_tilt, input ready);
   modport sink (input valid, input target_pan, input target_tilt, output ready);
endinterface

interface svpt_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [svpt_pkg::DUTY_W-1:0]              duty_pan;
   logic [svpt_pkg::DUTY_W-1:0]              duty_tilt;
   logic signed [svpt_pkg::ANGLE_W-1:0]      angle_pan;
   logic signed [svpt_pkg::ANGLE_TILT_W-1:0] angle_tilt;

   modport source (output valid, output duty_pan, output duty_tilt, output angle_pan,
                   output angle_tilt, input ready);
   modport sink (input valid, input duty_pan, input duty_tilt, input angle_pan,
                 input angle_tilt, output ready);
endinterface

// File: design/svpt_mul.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother digit-serial multiplier
// Signed by unsigned shift-and-add multiplier, one digit of the multiplier
// per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module svpt_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  svpt_pkg::mc_type              mcand,
   input  logic [svpt_pkg::MR_W-1:0]     mplier,
   output logic                          done,
   output svpt_pkg::prod_type            product
);

   typedef logic signed [svpt_pkg::MC_W+svpt_pkg::DIGIT_W-1:0] hi_type;

   svpt_pkg::mc_type                  mcand_ff, mcand_in;
   hi_type                            hi_ff, hi_in, addend, hi_sum;
   logic [svpt_pkg::MR_W-1:0]         lo_ff, lo_in;
   logic [svpt_pkg::MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [svpt_pkg::DIGIT_W-1:0]      digit;

   always_comb begin
      digit = lo_ff[svpt_pkg::DIGIT_W-1:0];
      addend = '0;
      for (int b = 0; b < svpt_pkg::DIGIT_W; b++) begin
         if (digit[b]) begin
            addend = addend + (hi_type'(mcand_ff) <<< b);
         end
      end
      hi_sum = hi_ff + addend;

      mcand_in = mcand_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mcand_in = mcand;
         hi_in = '0;
         lo_in = mplier;
         cnt_in = svpt_pkg::MUL_CNT_W'(svpt_pkg::MUL_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in = hi_sum >>> svpt_pkg::DIGIT_W;
         lo_in = {hi_sum[svpt_pkg::DIGIT_W-1:0], lo_ff[svpt_pkg::MR_W-1:svpt_pkg::DIGIT_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign product = svpt_pkg::prod_type'({hi_ff, lo_ff});

endmodule

// File: design/svpt_div.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother digit-serial divider
// Restoring divider by a small held divisor, one quotient digit per cycle,
// most significant digit first.
// ----------------------------------------------------------------------------
module svpt_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [svpt_pkg::DVD_W-1:0]     dividend,
   input  logic [svpt_pkg::REM_W-1:0]     divisor,
   output logic                           done,
   output logic [svpt_pkg::QUOT_W-1:0]    quotient
);

   typedef logic [svpt_pkg::REM_W+svpt_pkg::DIGIT_W-1:0] wide_type;

   logic [svpt_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [svpt_pkg::QUOT_W-1:0]      low_ff, low_in;
   wide_type                         mult_ff [svpt_pkg::DIGIT_MAX+1];
   wide_type                         mult_in [svpt_pkg::DIGIT_MAX+1];
   wide_type                         rem_sh, rem_diff;
   logic [svpt_pkg::DIGIT_W-1:0]     qd;
   logic [svpt_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   always_comb begin
      for (int k = 0; k <= svpt_pkg::DIGIT_MAX; k++) begin
         mult_in[k] = wide_type'(divisor) * wide_type'(k);
      end

      rem_sh = {rem_ff, low_ff[svpt_pkg::QUOT_W-1 -: svpt_pkg::DIGIT_W]};
      qd = '0;
      for (int k = 1; k <= svpt_pkg::DIGIT_MAX; k++) begin
         if (rem_sh >= mult_ff[k]) begin
            qd = svpt_pkg::DIGIT_W'(k);
         end
      end
      rem_diff = rem_sh - mult_ff[qd];

      rem_in = rem_ff;
      low_in = low_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[svpt_pkg::DVD_W-1:svpt_pkg::QUOT_W];
         low_in = dividend[svpt_pkg::QUOT_W-1:0];
         cnt_in = svpt_pkg::DIV_CNT_W'(svpt_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_diff[svpt_pkg::REM_W-1:0];
         low_in = {low_ff[svpt_pkg::QUOT_W-svpt_pkg::DIGIT_W-1:0], qd};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      if (start) begin
         mult_ff <= mult_in;
      end
   end

   assign done = done_ff;
   assign quotient = low_ff;

endmodule

// File: design/svpt_axis.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother axis lane
// Clamps and deadbands one target, steps the smoothed angle toward it and
// maps the angle to a PWM duty count, using a serial multiplier and divider.
// ----------------------------------------------------------------------------
module svpt_axis (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           axis_sel,
   input  svpt_pkg::axis_ctrl_type        ctrl,
   input  svpt_pkg::cfg_type              cfg,
   input  svpt_pkg::target_type           target,
   output svpt_pkg::axis_status_type      status,
   output logic [svpt_pkg::DUTY_W-1:0]    duty,
   output svpt_pkg::angle_type            angle
);

   typedef logic signed [svpt_pkg::SUM_W-1:0] sum_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_GATE,
      ST_GAIN_WAIT,
      ST_SPAN,
      ST_SPAN_WAIT,
      ST_LIM_WAIT,
      ST_PERIOD,
      ST_PERIOD_WAIT,
      ST_DONE
   } state_type;

   state_type                             state_ff;
   svpt_pkg::angle_type                   tgt_ff;
   svpt_pkg::angle_type                   cur_ff;
   svpt_pkg::mc_type                      diff_ff;
   svpt_pkg::mc_type                      mcand_ff;
   logic [svpt_pkg::MR_W-1:0]             mplier_ff;
   logic                                  mul_start_ff;
   logic [svpt_pkg::DVD_W-1:0]            dividend_ff;
   logic [svpt_pkg::REM_W-1:0]            divisor_ff;
   logic                                  div_start_ff;
   logic [svpt_pkg::PLS_W-1:0]            pulse_ff;
   logic [svpt_pkg::DUTY_EXT_W-1:0]       duty_ff;

   svpt_pkg::angle_type                   lim;
   logic [svpt_pkg::REM_W-1:0]            lim_divisor;
   svpt_pkg::mc_type                      db_s;
   logic                                  in_band;
   logic [svpt_pkg::PULSE_W-1:0]          span;
   sum_type                               step_sum;
   sum_type                               off_sum;
   logic [svpt_pkg::DVD_W-1:0]            pulse_ext;
   logic [svpt_pkg::DVD_W-1:0]            period_dvd;
   logic                                  mul_done;
   svpt_pkg::prod_type                    mul_product;
   logic                                  div_done;
   logic [svpt_pkg::QUOT_W-1:0]           div_quot;

   function automatic svpt_pkg::angle_type clamp_angle(input sum_type value,
                                                       input svpt_pkg::angle_type limit);
      sum_type bound;
      bound = sum_type'(limit);
      if (value > bound) begin
         return limit;
      end
      if (value < -bound) begin
         return -limit;
      end
      return svpt_pkg::angle_type'(value);
   endfunction

   svpt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mcand_ff),
      .mplier  (mplier_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   svpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      lim = axis_sel ? svpt_pkg::angle_type'(svpt_pkg::TILT_LIMIT)
                     : svpt_pkg::angle_type'(svpt_pkg::PAN_LIMIT);
      lim_divisor = axis_sel ? svpt_pkg::REM_W'(2 * svpt_pkg::TILT_LIMIT)
                             : svpt_pkg::REM_W'(2 * svpt_pkg::PAN_LIMIT);
      db_s = svpt_pkg::mc_type'({1'b0, cfg.deadband});
      in_band = (diff_ff < db_s) && (diff_ff > -db_s);
      span = (cfg.pulse_max_us >= cfg.pulse_min_us) ?
             cfg.pulse_max_us - cfg.pulse_min_us : '0;
      step_sum = sum_type'($signed(mul_product[svpt_pkg::PROD_W-1:svpt_pkg::GAIN_FRAC]))
                 + sum_type'(cur_ff);
      off_sum = sum_type'(cur_ff) + sum_type'(lim);
      pulse_ext = svpt_pkg::DVD_W'(pulse_ff);
      period_dvd = (pulse_ext << svpt_pkg::DUTY_BITS) - pulse_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (ctrl.start) begin
                  tgt_ff <= clamp_angle(sum_type'(target), lim);
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               diff_ff <= svpt_pkg::mc_type'(tgt_ff) - svpt_pkg::mc_type'(cur_ff);
               state_ff <= ST_GATE;
            end
            ST_GATE: begin
               mcand_ff <= in_band ? '0 : diff_ff;
               mplier_ff <= svpt_pkg::MR_W'(cfg.gain);
               mul_start_ff <= 1'b1;
               state_ff <= ST_GAIN_WAIT;
            end
            ST_GAIN_WAIT: begin
               if (mul_done) begin
                  cur_ff <= clamp_angle(step_sum, lim);
                  state_ff <= ST_SPAN;
               end
            end
            ST_SPAN: begin
               mcand_ff <= svpt_pkg::mc_type'(off_sum);
               mplier_ff <= svpt_pkg::MR_W'(span);
               mul_start_ff <= 1'b1;
               state_ff <= ST_SPAN_WAIT;
            end
            ST_SPAN_WAIT: begin
               if (mul_done) begin
                  dividend_ff <= svpt_pkg::DVD_W'($unsigned(mul_product));
                  divisor_ff <= lim_divisor;
                  div_start_ff <= 1'b1;
                  state_ff <= ST_LIM_WAIT;
               end
            end
            ST_LIM_WAIT: begin
               if (div_done) begin
                  pulse_ff <= svpt_pkg::PLS_W'(cfg.pulse_min_us)
                              + svpt_pkg::PLS_W'(div_quot[svpt_pkg::PULSE_W-1:0]);
                  state_ff <= ST_PERIOD;
               end
            end
            ST_PERIOD: begin
               dividend_ff <= period_dvd;
               divisor_ff <= svpt_pkg::REM_W'(svpt_pkg::PERIOD_US);
               div_start_ff <= 1'b1;
               state_ff <= ST_PERIOD_WAIT;
            end
            ST_PERIOD_WAIT: begin
               if (div_done) begin
                  duty_ff <= (div_quot > svpt_pkg::QUOT_W'(svpt_pkg::DUTY_MAX)) ?
                             svpt_pkg::DUTY_EXT_W'(svpt_pkg::DUTY_MAX) :
                             svpt_pkg::DUTY_EXT_W'(div_quot);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (ctrl.ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign duty = duty_ff[svpt_pkg::DUTY_W-1:0];
   assign angle = cur_ff;

endmodule

// File: design/servo_pan_tilt_smoother_top.sv
// ----------------------------------------------------------------------------
// Servo pan/tilt smoother
// Smooths pan/tilt servo targets and maps them to PWM duty counts.
// ----------------------------------------------------------------------------
// A request on req_if carries a pan and a tilt target in 1/256 degree.
// The response on rsp_if carries the two duty counts and the two smoothed
// angles after the update. There is exactly one response per request.
// The csr port writes the gain, deadband and pulse limits; it must only be
// written while no request is in flight.
// Each axis runs in its own lane with a multiplier and a divider that
// handle two bits per cycle. Each update takes two multiplies and two
// divides per lane plus the steps around them. A new request is taken
// in the cycle after the previous response is loaded, so a request is
// not accepted while the previous one is still in flight.
// The response sits in an output register, so a stalled receiver does not
// block the next request; the one after that waits until the response is
// taken. Reset restores the register defaults and zeroes both angles.
// ----------------------------------------------------------------------------
module servo_pan_tilt_smoother_top (
   input  logic                                clock,
   input  logic                                reset,
   svpt_req_if.sink                            req_if,
   svpt_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [svpt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [svpt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   svpt_pkg::cfg_type                       cfg_ff;
   svpt_pkg::axis_ctrl_type                 axis_ctrl;
   svpt_pkg::axis_status_type               pan_status;
   svpt_pkg::axis_status_type               tilt_status;
   logic [svpt_pkg::DUTY_W-1:0]             pan_duty;
   logic [svpt_pkg::DUTY_W-1:0]             tilt_duty;
   svpt_pkg::angle_type                     pan_angle;
   svpt_pkg::angle_type                     tilt_angle;
   logic                                    load_out;
   logic                                    rsp_valid_ff;
   logic [svpt_pkg::DUTY_W-1:0]             duty_pan_ff;
   logic [svpt_pkg::DUTY_W-1:0]             duty_tilt_ff;
   svpt_pkg::angle_type                     angle_pan_ff;
   logic signed [svpt_pkg::ANGLE_TILT_W-1:0] angle_tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain <= svpt_pkg::GAIN_W'(svpt_pkg::GAIN_RESET);
         cfg_ff.deadband <= svpt_pkg::DEADBAND_W'(svpt_pkg::DEADBAND_RESET);
         cfg_ff.pulse_min_us <= svpt_pkg::PULSE_W'(svpt_pkg::PULSE_MIN_RESET);
         cfg_ff.pulse_max_us <= svpt_pkg::PULSE_W'(svpt_pkg::PULSE_MAX_RESET);
      end else if (csr_we) begin
         case (csr_index)
            svpt_pkg::CSR_GAIN: begin
               cfg_ff.gain <= csr_wdata[svpt_pkg::GAIN_W-1:0];
            end
            svpt_pkg::CSR_DEADBAND: begin
               cfg_ff.deadband <= csr_wdata[svpt_pkg::DEADBAND_W-1:0];
            end
            svpt_pkg::CSR_PULSE_MIN: begin
               cfg_ff.pulse_min_us <= csr_wdata[svpt_pkg::PULSE_W-1:0];
            end
            svpt_pkg::CSR_PULSE_MAX: begin
               cfg_ff.pulse_max_us <= csr_wdata[svpt_pkg::PULSE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready = pan_status.idle & tilt_status.idle;
   assign load_out = pan_status.done & tilt_status.done & (~rsp_valid_ff | rsp_if.ready);
   assign axis_ctrl.start = req_if.valid & req_if.ready;
   assign axis_ctrl.ack = load_out;

   svpt_axis u_pan (
      .clock    (clock),
      .reset    (reset),
      .axis_sel (1'b0),
      .ctrl     (axis_ctrl),
      .cfg      (cfg_ff),
      .target   (req_if.target_pan),
      .status   (pan_status),
      .duty     (pan_duty),
      .angle    (pan_angle)
   );

   svpt_axis u_tilt (
      .clock    (clock),
      .reset    (reset),
      .axis_sel (1'b1),
      .ctrl     (axis_ctrl),
      .cfg      (cfg_ff),
      .target   (req_if.target_tilt),
      .status   (tilt_status),
      .duty     (tilt_duty),
      .angle    (tilt_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         duty_pan_ff <= pan_duty;
         duty_tilt_ff <= tilt_duty;
         angle_pan_ff <= pan_angle;
         angle_tilt_ff <= $signed(tilt_angle[svpt_pkg::ANGLE_TILT_W-1:0]);
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.duty_pan = duty_pan_ff;
   assign rsp_if.duty_tilt = duty_tilt_ff;
   assign rsp_if.angle_pan = angle_pan_ff;
   assign rsp_if.angle_tilt = angle_tilt_ff;

endmodule
